// ===== design/pgtk_pkg.sv =====
package pgtk_pkg;

    localparam int TOP_K_DEF  = 8;
    localparam int GROUPS_DEF = 5;

    localparam int GROUP_W = 3;
    localparam int RANK_W  = 3;
    localparam int CMD_W   = 3;
    localparam int SCORE_W = 24;
    localparam int CNT16_W = 16;
    localparam int DIST_W  = 24;
    localparam int OUT_CNT_W = 4;

    // Command codes carried in s_axis_tuser
    localparam logic [CMD_W-1:0] CMD_SUBMIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MODE_BEST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALL_BEST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_RANK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

    // One stored record; score sits in the low bits
    typedef struct packed {
        logic               mode;
        logic [CNT16_W-1:0] play_time;
        logic [DIST_W-1:0]  distance;
        logic [CNT16_W-1:0] powerups;
        logic [CNT16_W-1:0] combo;
        logic [CNT16_W-1:0] enemies;
        logic [SCORE_W-1:0] score;
    } record_t;

    localparam int REC_W = $bits(record_t);

    // Input tdata layout: group, rank, then the record
    localparam int IN_REC_LSB = GROUP_W + RANK_W;
    localparam int DATA_W     = 120;

endpackage

// ===== design/per_group_top_k_score_table_unit.sv =====
// A submit on a full list first compares with the lowest record; it then shifts each lower
//   record down one slot and writes the new one. A refused submit ends at that comparison.
//   Mode-best walks the list; overall best visits each group head; read rank reads one slot
//   (none on a miss); clear and unknown commands go to S_DONE; a stalled m_axis stretches any.
// One transaction at a time; the next input is taken once S_DONE hands off the result.
// Reset (aresetn low, synchronous) empties every group list; the record RAM is not cleared.
module per_group_top_k_score_table_unit #(
    parameter int TOP_K  = pgtk_pkg::TOP_K_DEF,
    parameter int GROUPS = pgtk_pkg::GROUPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // group[2:0], rank[5:3], new_score[29:6], new_enemies[45:30], new_combo[61:46],
    // new_powerups[77:62], new_distance[101:78], new_time[117:102], mode_flag[118]
    input  logic [pgtk_pkg::DATA_W-1:0] s_axis_tdata,
    // command[2:0]
    input  logic [pgtk_pkg::CMD_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_score[23:0], out_enemies[39:24], out_combo[55:40], out_powerups[71:56],
    // out_distance[95:72], out_time[111:96], out_mode[112], group_count[116:113]
    output logic [pgtk_pkg::DATA_W-1:0] m_axis_tdata,
    // accepted[0], found[1]
    output logic [1:0]                  m_axis_tuser
);

    import pgtk_pkg::*;

    localparam int SLOTS  = GROUPS * TOP_K;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(TOP_K + 1);
    localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_CHK = 4'd1;  // full list: compare with the lowest record
    localparam logic [3:0] S_INS_CMP = 4'd2;  // walk down, shifting records by one slot
    localparam logic [3:0] S_INS_PUT = 4'd3;  // place the new record at slot 0
    localparam logic [3:0] S_MQ      = 4'd4;  // mode-best walk
    localparam logic [3:0] S_OB_STEP = 4'd5;  // overall best: pick next group head
    localparam logic [3:0] S_OB_CMP  = 4'd6;  // overall best: compare head score
    localparam logic [3:0] S_RR      = 4'd7;  // read rank data return
    localparam logic [3:0] S_DONE    = 4'd8;  // hand result to the output register

    logic [3:0]        state_reg, state_next;
    logic [GIDX_W-1:0] grp_reg, grp_next;
    logic [GIDX_W-1:0] gi_reg, gi_next;
    record_t           new_rec_reg, new_rec_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  counts_reg [GROUPS];
    logic [CNT_W-1:0]  counts_next [GROUPS];

    logic              res_acc_reg, res_acc_next;
    logic              res_found_reg, res_found_next;
    record_t           res_rec_reg, res_rec_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 out_acc_reg, out_acc_next;
    logic                 out_found_reg, out_found_next;
    record_t              out_rec_reg, out_rec_next;
    logic [OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    record_t           wr_data;
    logic [REC_W-1:0]  rd_raw;
    record_t           rd_rec;

    logic [GROUP_W-1:0] in_group;
    logic [GIDX_W-1:0]  in_grp_clip;
    logic [CNT_W-1:0]   in_cnt;
    logic [CNT_W-1:0]   cur_cnt;

    pgtk_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS),
        .AW    (ADDR_W)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_rec = record_t'(rd_raw);

    // Out-of-range groups fold onto group 0
    assign in_group    = s_axis_tdata[GROUP_W-1:0];
    assign in_grp_clip = ({1'b0, in_group} < (GROUP_W + 1)'(GROUPS)) ?
                         GIDX_W'(in_group) : '0;
    assign in_cnt      = counts_reg[in_grp_clip];
    assign cur_cnt     = counts_reg[grp_reg];

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        gi_next        = gi_reg;
        new_rec_next   = new_rec_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        counts_next    = counts_reg;
        res_acc_next   = res_acc_reg;
        res_found_next = res_found_reg;
        res_rec_next   = res_rec_reg;
        m_valid_next   = m_valid_reg;
        out_acc_next   = out_acc_reg;
        out_found_next = out_found_reg;
        out_rec_next   = out_rec_reg;
        out_cnt_next   = out_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = base_reg;
        wr_data        = new_rec_reg;
        rd_en          = 1'b0;
        rd_addr        = base_reg;

        // Retire the output transaction
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    grp_next       = in_grp_clip;
                    new_rec_next   = record_t'(s_axis_tdata[IN_REC_LSB+REC_W-1:IN_REC_LSB]);
                    base_next      = ADDR_W'(in_grp_clip) * ADDR_W'(TOP_K);
                    res_acc_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_rec_next   = '0;
                    idx_next       = '0;
                    gi_next        = '0;
                    state_next     = S_DONE;
                    case (s_axis_tuser)
                        CMD_SUBMIT: begin
                            rd_en = 1'b1;
                            if (in_cnt == CNT_W'(TOP_K)) begin
                                rd_addr    = base_next + ADDR_W'(TOP_K - 1);
                                state_next = S_INS_CHK;
                            end else if (in_cnt == '0) begin
                                state_next = S_INS_PUT;
                            end else begin
                                idx_next   = in_cnt;
                                rd_addr    = base_next + ADDR_W'(in_cnt) - ADDR_W'(1);
                                state_next = S_INS_CMP;
                            end
                        end
                        CMD_MODE_BEST: begin
                            if (in_cnt != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = base_next;
                                state_next = S_MQ;
                            end
                        end
                        CMD_ALL_BEST: begin
                            state_next = S_OB_STEP;
                        end
                        CMD_READ_RANK: begin
                            if (int'(s_axis_tdata[IN_REC_LSB-1:GROUP_W]) < int'(in_cnt)) begin
                                rd_en      = 1'b1;
                                rd_addr    = base_next
                                           + ADDR_W'(s_axis_tdata[IN_REC_LSB-1:GROUP_W]);
                                state_next = S_RR;
                            end
                        end
                        CMD_CLEAR: begin
                            for (int g = 0; g < GROUPS; g++) begin
                                counts_next[g] = '0;
                            end
                        end
                        default: begin
                            // unknown command: lists unchanged, an empty result is returned
                        end
                    endcase
                end
            end

            S_INS_CHK: begin
                if (new_rec_reg.score > rd_rec.score) begin
                    // the lowest record drops off the end
                    idx_next = CNT_W'(TOP_K - 1);
                    if (TOP_K == 1) begin
                        state_next = S_INS_PUT;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = base_reg + ADDR_W'(TOP_K - 2);
                        state_next = S_INS_CMP;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end

            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = base_reg + ADDR_W'(idx_reg);
                if (rd_rec.score >= new_rec_reg.score) begin
                    // place after every equal or higher score
                    wr_data      = new_rec_reg;
                    res_acc_next = 1'b1;
                    if (cur_cnt != CNT_W'(TOP_K)) begin
                        counts_next[grp_reg] = cur_cnt + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end else begin
                    wr_data  = rd_rec;
                    idx_next = idx_reg - CNT_W'(1);
                    if (idx_reg == CNT_W'(1)) begin
                        state_next = S_INS_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = base_reg + ADDR_W'(idx_reg) - ADDR_W'(2);
                    end
                end
            end

            S_INS_PUT: begin
                wr_en        = 1'b1;
                wr_addr      = base_reg;
                wr_data      = new_rec_reg;
                res_acc_next = 1'b1;
                if (cur_cnt != CNT_W'(TOP_K)) begin
                    counts_next[grp_reg] = cur_cnt + CNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_MQ: begin
                if (rd_rec.mode == new_rec_reg.mode) begin
                    res_found_next     = 1'b1;
                    res_rec_next.score = rd_rec.score;
                    state_next         = S_DONE;
                end else if (idx_reg + CNT_W'(1) == cur_cnt) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = base_reg + ADDR_W'(idx_reg) + ADDR_W'(1);
                end
            end

            S_OB_STEP: begin
                if (counts_reg[gi_reg] != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(gi_reg) * ADDR_W'(TOP_K);
                    state_next = S_OB_CMP;
                end else if (gi_reg == GIDX_W'(GROUPS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    gi_next = gi_reg + GIDX_W'(1);
                end
            end

            S_OB_CMP: begin
                res_found_next = 1'b1;
                if (rd_rec.score > res_rec_reg.score) begin
                    res_rec_next.score = rd_rec.score;
                end
                if (gi_reg == GIDX_W'(GROUPS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    gi_next    = gi_reg + GIDX_W'(1);
                    state_next = S_OB_STEP;
                end
            end

            S_RR: begin
                res_found_next = 1'b1;
                res_rec_next   = rd_rec;
                state_next     = S_DONE;
            end

            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next   = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_found_next = res_found_reg;
                    out_rec_next   = res_rec_reg;
                    out_cnt_next   = OUT_CNT_W'(cur_cnt);
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            grp_reg     <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                counts_reg[g] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            grp_reg     <= grp_next;
            counts_reg  <= counts_next;
        end
    end

    always_ff @(posedge aclk) begin
        gi_reg        <= gi_next;
        new_rec_reg   <= new_rec_next;
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        res_acc_reg   <= res_acc_next;
        res_found_reg <= res_found_next;
        res_rec_reg   <= res_rec_next;
        out_acc_reg   <= out_acc_next;
        out_found_reg <= out_found_next;
        out_rec_reg   <= out_rec_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(DATA_W - REC_W - OUT_CNT_W)'(0), out_cnt_reg, out_rec_reg};
    assign m_axis_tuser  = {out_found_reg, out_acc_reg};

    // A new transaction is never taken while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // Only the insertion walk writes the record RAM
    a_wr_in_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((state_reg == S_INS_CMP) || (state_reg == S_INS_PUT)))
        else $error("record RAM written outside insertion");

    // A submit result never reports a found record
    a_acc_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("accepted and found both set");

    // Without a found record the whole answered record is zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (out_rec_reg == '0))
        else $error("record fields nonzero without a found record");

    // A group list never grows beyond TOP_K
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cur_cnt) <= TOP_K)
        else $error("group count above TOP_K");

    // The walk reads the slot two above the one it writes (toward slot 0)
    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_CMP && rd_en) |-> (rd_addr + ADDR_W'(2) == wr_addr))
        else $error("shift read and write addresses out of step");

endmodule

// ===== design/pgtk_ram.sv =====
module pgtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
